>>> design/olid_pkg.sv
// Package for the ordered list: sizes, command and status codes, cell control type.
package olid_pkg;

  localparam int CAPACITY = 16;

  localparam int VAL_W = 32;
  localparam int CMD_W = 3;
  localparam int POS_W = 5;
  localparam int STATUS_W = 2;
  localparam int LEN_W = 5;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_INS_POS   = 3'd2,
    CMD_DEL_FRONT = 3'd3,
    CMD_DEL_BACK  = 3'd4,
    CMD_DEL_POS   = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_POS   = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // Control broadcast to every cell in the chain.
  typedef struct packed {
    logic             ins;
    logic             del;
    logic [IDX_W-1:0] at;
  } cell_ctl_t;

endpackage

>>> design/olid_cell.sv
// One storage cell of the list chain.
module olid_cell (
  input  logic                       clk,
  input  olid_pkg::cell_ctl_t        ctl,
  input  logic [olid_pkg::IDX_W-1:0] idx,
  input  logic [olid_pkg::VAL_W-1:0] new_val,
  input  logic [olid_pkg::VAL_W-1:0] left_val,
  input  logic [olid_pkg::VAL_W-1:0] right_val,
  output logic [olid_pkg::VAL_W-1:0] val
);
  import olid_pkg::*;

  logic [VAL_W-1:0] val_r;
  logic [VAL_W-1:0] val_nxt;

  // On insert the cells at and beyond the point move up by one; on delete
  // the cells at and beyond the point take their right neighbour's value.
  always_comb begin
    val_nxt = val_r;
    if (ctl.ins) begin
      if (idx == ctl.at) begin
        val_nxt = new_val;
      end else if (idx > ctl.at) begin
        val_nxt = left_val;
      end
    end else if (ctl.del) begin
      if (idx >= ctl.at) begin
        val_nxt = right_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

>>> design/ordered_list_insert_delete.sv
// Top level of the ordered list with positional insert and delete.
//
//   Channel | Direction | Handshake          | Payload
//   --------+-----------+--------------------+-------------------------------------
//   in_     | input     | in_valid/in_stall  | in_command, in_value, in_position
//   out_    | output    | out_valid/out_stall| out_status, out_new_length,
//           |           |                    | out_removed_value
//
// Every command is decoded, checked against the element count and applied to
// the chain of cells in the cycle it is accepted, and its result is registered
// for the output at the same edge. A new command may therefore be accepted
// every cycle while no waiting result is stalled. The cells shift in parallel,
// so the position of an insert or delete does not change the timing.
// Reset (synchronous, active low) clears the element count and the output
// valid flag; cell contents are left as they are, since only cells below the
// count are ever read. When a result is waiting and the output is stalled, the
// input is stalled as well; it is released in the cycle the result is taken.
module ordered_list_insert_delete (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [olid_pkg::CMD_W-1:0]          in_command,
  input  logic signed [olid_pkg::VAL_W-1:0]   in_value,
  input  logic [olid_pkg::POS_W-1:0]          in_position,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [olid_pkg::STATUS_W-1:0]       out_status,
  output logic [olid_pkg::LEN_W-1:0]          out_new_length,
  output logic signed [olid_pkg::VAL_W-1:0]   out_removed_value
);
  import olid_pkg::*;

  logic                accept;
  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    count_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic [STATUS_W-1:0] status_r;
  logic [LEN_W-1:0]    new_length_r;
  logic [VAL_W-1:0]    removed_r;

  status_t             status_c;
  logic [VAL_W-1:0]    removed_c;
  cell_ctl_t           ctl;
  logic [VAL_W-1:0]    cell_val [CAPACITY];

  logic                is_empty;
  logic                is_full;
  logic [CMP_W-1:0]    pos_ext;
  logic [CMP_W-1:0]    cnt_ext;
  logic                pos_bad;
  logic [IDX_W-1:0]    at_back;
  logic [IDX_W-1:0]    at_last;
  logic [IDX_W-1:0]    at_pos;
  logic [CNT_W-1:0]    count_dec;

  // The output register is the only buffer: input is held off only while a
  // result is waiting and the far side is stalling.
  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign is_empty  = (count_r == '0);
  assign is_full   = (count_r == CNT_W'(CAPACITY));
  assign pos_ext   = CMP_W'(in_position);
  assign cnt_ext   = CMP_W'(count_r);
  assign pos_bad   = (pos_ext > cnt_ext);
  assign count_dec = count_r - CNT_W'(1);
  assign at_back   = count_r[IDX_W-1:0];
  assign at_last   = count_dec[IDX_W-1:0];
  assign at_pos    = pos_ext[IDX_W-1:0];

  // Command decode and checks. The insert point is only used when the list
  // is not full, so the count always fits the cell index there. A positional
  // delete at the count itself removes the last element.
  always_comb begin
    status_c  = ST_OK;
    ctl       = '0;
    count_nxt = count_r;
    case (cmd_t'(in_command))
      CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_POS: begin
        if ((cmd_t'(in_command) == CMD_INS_POS) && is_empty) begin
          status_c = ST_EMPTY;
        end else if ((cmd_t'(in_command) == CMD_INS_POS) && pos_bad) begin
          status_c = ST_POS;
        end else if (is_full) begin
          status_c = ST_FULL;
        end else begin
          ctl.ins   = 1'b1;
          count_nxt = count_r + CNT_W'(1);
          if (cmd_t'(in_command) == CMD_INS_FRONT) begin
            ctl.at = '0;
          end else if (cmd_t'(in_command) == CMD_INS_BACK) begin
            ctl.at = at_back;
          end else begin
            ctl.at = at_pos;
          end
        end
      end
      CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_POS: begin
        if (is_empty) begin
          status_c = ST_EMPTY;
        end else if ((cmd_t'(in_command) == CMD_DEL_POS) && pos_bad) begin
          status_c = ST_POS;
        end else begin
          ctl.del   = 1'b1;
          count_nxt = count_dec;
          if (cmd_t'(in_command) == CMD_DEL_FRONT) begin
            ctl.at = '0;
          end else if (cmd_t'(in_command) == CMD_DEL_BACK) begin
            ctl.at = at_last;
          end else if (pos_ext == cnt_ext) begin
            ctl.at = at_last;
          end else begin
            ctl.at = at_pos;
          end
        end
      end
      default: begin
        status_c = ST_OK;
      end
    endcase
    if (!accept) begin
      ctl.ins   = 1'b0;
      ctl.del   = 1'b0;
      count_nxt = count_r;
    end
  end

  // The removed element is read from the chain before it shifts.
  assign removed_c = ctl.del ? cell_val[ctl.at] : '0;

  // The chain of cells: each takes its left neighbour on insert and its right
  // neighbour on delete. The ends see zero beyond the chain.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [VAL_W-1:0] left_val;
    logic [VAL_W-1:0] right_val;
    if (g == 0) begin : g_first
      assign left_val = '0;
    end else begin : g_mid_l
      assign left_val = cell_val[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_val = '0;
    end else begin : g_mid_r
      assign right_val = cell_val[g+1];
    end
    olid_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .idx       (IDX_W'(g)),
      .new_val   ($unsigned(in_value)),
      .left_val  (left_val),
      .right_val (right_val),
      .val       (cell_val[g])
    );
  end

  assign out_valid_nxt = accept | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r     <= status_c;
      new_length_r <= LEN_W'(count_nxt);
      removed_r    <= removed_c;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_new_length    = new_length_r;
  assign out_removed_value = $signed(removed_r);

endmodule

>>> dv/tb_ordered_list_insert_delete.sv
`timescale 1ns / 1ps
// Self-checking testbench for the ordered list: directed edge cases, fill and drain runs, random commands.
module tb_ordered_list_insert_delete;
  import olid_pkg::*;

  // Command codes the block does not define. They must leave the list alone and
  // report ok with the current length.
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  // Several times the slowest legal run: every item waiting out the longest
  // sender gap and the longest output stall.
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    status_t                 status;
    logic [LEN_W-1:0]        new_length;
    logic signed [VAL_W-1:0] removed_value;
  } list_result_t;

  // Direction in which a random run pushes the list length.
  typedef enum {DRIFT_GROW, DRIFT_SHRINK, DRIFT_LEVEL} drift_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [CMD_W-1:0]        in_command = '0;
  logic signed [VAL_W-1:0] in_value = '0;
  logic [POS_W-1:0]        in_position = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [STATUS_W-1:0]     out_status;
  logic [LEN_W-1:0]        out_new_length;
  logic signed [VAL_W-1:0] out_removed_value;

  ordered_list_insert_delete DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_value          (in_value),
    .in_position       (in_position),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_new_length    (out_new_length),
    .out_removed_value (out_removed_value)
  );

  always #2 clk = ~clk;

  // The testbench's own copy of the list. Element 0 is the front; only entries
  // below list_len hold meaningful values.
  logic signed [VAL_W-1:0] list_copy [CAPACITY];
  int                      list_len = 0;

  // Results owed by the block, oldest first.
  list_result_t            pending_results [$];
  int                      mismatches = 0;

  // Idling knobs, in percent per opportunity. They are changed between runs so
  // that busy stretches alternate with stretches where neither side pauses.
  int                      send_idle_pct = 0;
  int                      take_idle_pct = 0;
  int                      stall_left = 0;

  // Most pauses are short; now and then a long one.
  function automatic int idle_length();
    if ($urandom_range(99) < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int idle_pct();
    case ($urandom_range(3))
      0: return 0;
      1: return 10;
      2: return 30;
      default: return 60;
    endcase
  endfunction

  // Values lean towards the extremes so that the sign bit and the all-ones
  // pattern travel through the cells often.
  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(15))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CMD_W-1:0] pick_insert();
    case ($urandom_range(2))
      0: return CMD_INS_FRONT;
      1: return CMD_INS_BACK;
      default: return CMD_INS_POS;
    endcase
  endfunction

  function automatic logic [CMD_W-1:0] pick_delete();
    case ($urandom_range(2))
      0: return CMD_DEL_FRONT;
      1: return CMD_DEL_BACK;
      default: return CMD_DEL_POS;
    endcase
  endfunction

  function automatic logic [CMD_W-1:0] pick_command(input int insert_pct);
    if ($urandom_range(99) < 2) return $urandom_range(1) ? CMD_SPARE_HI : CMD_SPARE_LO;
    if ($urandom_range(99) < insert_pct) return pick_insert();
    return pick_delete();
  endfunction

  // Mostly a legal position for the current length, sometimes one beyond it up
  // to the capacity, and sometimes anything from zero to the capacity.
  function automatic logic [POS_W-1:0] pick_position();
    int roll;
    roll = $urandom_range(99);
    if (roll < 80) return POS_W'($urandom_range(0, list_len));
    if (roll < 90 && list_len < CAPACITY) return POS_W'($urandom_range(list_len + 1, CAPACITY));
    return POS_W'($urandom_range(0, CAPACITY));
  endfunction

  // Insert into the copy; a position beyond the end appends.
  function automatic status_t list_insert(input int at, input logic signed [VAL_W-1:0] val);
    int i;
    if (list_len >= CAPACITY) return ST_FULL;
    if (at > list_len) at = list_len;
    for (i = list_len; i > at; i--) list_copy[i] = list_copy[i-1];
    list_copy[at] = val;
    list_len++;
    return ST_OK;
  endfunction

  // Remove from the copy; a position at or beyond the end takes the last element.
  function automatic status_t list_remove(input int at, output logic signed [VAL_W-1:0] taken);
    int i;
    taken = '0;
    if (list_len == 0) return ST_EMPTY;
    if (at >= list_len) at = list_len - 1;
    taken = list_copy[at];
    for (i = at; i + 1 < list_len; i++) list_copy[i] = list_copy[i+1];
    list_len--;
    return ST_OK;
  endfunction

  // Applies one command to the copy and returns the result the block owes.
  // Positional commands check for an empty list first, then the position; only
  // then can an insert find the list full.
  function automatic list_result_t predict_result(input logic [CMD_W-1:0] cmd,
                                                  input logic signed [VAL_W-1:0] val,
                                                  input logic [POS_W-1:0] pos);
    list_result_t            res;
    logic signed [VAL_W-1:0] taken;
    res.status = ST_OK;
    taken = '0;
    case (cmd)
      CMD_INS_FRONT: res.status = list_insert(0, val);
      CMD_INS_BACK:  res.status = list_insert(list_len, val);
      CMD_INS_POS: begin
        if (list_len == 0) res.status = ST_EMPTY;
        else if (int'(pos) > list_len) res.status = ST_POS;
        else res.status = list_insert(int'(pos), val);
      end
      CMD_DEL_FRONT: res.status = list_remove(0, taken);
      CMD_DEL_BACK:  res.status = list_remove(list_len, taken);
      CMD_DEL_POS: begin
        if (list_len == 0) res.status = ST_EMPTY;
        else if (int'(pos) > list_len) res.status = ST_POS;
        else res.status = list_remove(int'(pos), taken);
      end
      default: ;
    endcase
    res.removed_value = taken;
    res.new_length = LEN_W'(list_len);
    return res;
  endfunction

  // Offers one item, optionally after a pause, and holds it until the block
  // takes it. The expectation is worked out at the edge of acceptance, so the
  // copy of the list is always current when the next item is chosen.
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic signed [VAL_W-1:0] val,
                           input logic [POS_W-1:0] pos);
    int gap;
    gap = ($urandom_range(99) < send_idle_pct) ? idle_length() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_command  <= cmd;
    in_value    <= val;
    in_position <= pos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_result(cmd, val, pos));
  endtask

  // Output stall: a pause is started at random and then held for its length.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if ($urandom_range(99) < take_idle_pct) begin
      stall_left <= idle_length() - 1;
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Every result taken by the testbench is matched against the oldest
  // expectation. Sampling happens on the rising edge, before the block's
  // registers move, so the values seen are those the handshake saw.
  always @(posedge clk) begin : result_check
    list_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d, new_length %0d, removed_value %0d",
               out_status, out_new_length, out_removed_value);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_status);
          mismatches++;
        end
        if (out_new_length !== want.new_length) begin
          $error("new_length: expected %0d, actual %0d", want.new_length, out_new_length);
          mismatches++;
        end
        if (out_removed_value !== want.removed_value) begin
          $error("removed_value: expected %0d, actual %0d",
                 want.removed_value, out_removed_value);
          mismatches++;
        end
      end
    end
  end

  // Every delete, and a positional insert, on a list with nothing in it must
  // report empty. The unused command codes must do nothing at all.
  task automatic test_empty_list();
    send_item(CMD_DEL_FRONT, pick_value(), '0);
    send_item(CMD_DEL_BACK, pick_value(), '0);
    send_item(CMD_DEL_POS, pick_value(), POS_W'(CAPACITY));
    send_item(CMD_INS_POS, VAL_MAX, '0);
    send_item(CMD_SPARE_LO, pick_value(), '1);
    send_item(CMD_SPARE_HI, pick_value(), '0);
  endtask

  // Builds a short list of extreme values through each insert, then takes it
  // apart through each delete, probing the boundary of the position range on
  // the way. The list is empty again at the end.
  task automatic test_positional_edges();
    send_item(CMD_INS_FRONT, VAL_MAX, '0);
    send_item(CMD_INS_BACK, VAL_MIN, '0);
    // One past the length is refused for an insert.
    send_item(CMD_INS_POS, '1, 5'd3);
    // A position equal to the length appends.
    send_item(CMD_INS_POS, '1, 5'd2);
    send_item(CMD_INS_POS, '0, 5'd0);
    send_item(CMD_INS_POS, 32'sh5a5a_a5a5, 5'd1);
    send_item(CMD_SPARE_HI, pick_value(), 5'd1);
    // Beyond the length is refused for a delete too.
    send_item(CMD_DEL_POS, pick_value(), 5'd6);
    // A position equal to the length removes the last element.
    send_item(CMD_DEL_POS, pick_value(), 5'd5);
    send_item(CMD_DEL_POS, pick_value(), 5'd1);
    send_item(CMD_DEL_POS, pick_value(), 5'd0);
    send_item(CMD_DEL_FRONT, pick_value(), '0);
    send_item(CMD_DEL_BACK, pick_value(), '0);
  endtask

  // Fills the list to capacity with random content, shows that every kind of
  // insert is then refused as full, and drains it again with random deletes.
  task automatic test_fill_and_drain();
    while (list_len < CAPACITY) begin
      send_item(list_len == 0 ? ($urandom_range(1) ? CMD_INS_FRONT : CMD_INS_BACK) : pick_insert(),
                pick_value(), POS_W'($urandom_range(0, list_len)));
    end
    send_item(CMD_INS_FRONT, pick_value(), '0);
    send_item(CMD_INS_BACK, pick_value(), '0);
    send_item(CMD_INS_POS, pick_value(), POS_W'(CAPACITY));
    send_item(CMD_INS_POS, pick_value(), POS_W'($urandom_range(0, CAPACITY - 1)));
    send_item(CMD_DEL_POS, pick_value(), POS_W'(CAPACITY));
    while (list_len > 0) begin
      send_item(pick_delete(), pick_value(), POS_W'($urandom_range(0, list_len)));
    end
  endtask

  // Random commands in runs that push the length up, down or leave it about
  // level, so the list keeps sweeping between empty and full. Each run also
  // draws fresh idling on both sides.
  task automatic test_random_ops(input int n_items);
    int     done;
    int     run_left;
    int     insert_pct;
    drift_t drift;
    done = 0;
    run_left = 0;
    insert_pct = 50;
    while (done < n_items) begin
      if (run_left == 0) begin
        run_left = $urandom_range(20, 60);
        drift = drift_t'($urandom_range(2));
        case (drift)
          DRIFT_GROW:   insert_pct = 75;
          DRIFT_SHRINK: insert_pct = 25;
          default:      insert_pct = 50;
        endcase
        send_idle_pct = idle_pct();
        take_idle_pct = idle_pct();
      end
      send_item(pick_command(insert_pct), pick_value(), pick_position());
      run_left--;
      done++;
    end
  endtask

  // Stops a run that has hung.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 20;
    take_idle_pct = 20;
    test_empty_list();
    test_positional_edges();
    repeat (3) test_fill_and_drain();
    test_random_ops(1150);
    in_valid <= 1'b0;
    take_idle_pct = 0;
    // Wait for every owed result, then keep watching for any stray one.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> files.f
design/olid_pkg.sv
design/olid_cell.sv
design/ordered_list_insert_delete.sv
dv/tb_ordered_list_insert_delete.sv
